// ----- src/dtq_pkg.sv -----
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and codes of the delta timer queue.
// Command, event and status codes, the sleep list entry layout and the push request.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam logic [2:0] CMD_ENQUEUE  = 3'd0;
	localparam logic [2:0] CMD_DISPATCH = 3'd1;
	localparam logic [2:0] CMD_SLEEP    = 3'd2;
	localparam logic [2:0] CMD_CANCEL   = 3'd3;
	localparam logic [2:0] CMD_TICK     = 3'd4;

	localparam logic [1:0] EV_ACK      = 2'd0;
	localparam logic [1:0] EV_DISPATCH = 2'd1;
	localparam logic [1:0] EV_WOKEN    = 2'd2;
	localparam logic [1:0] EV_NONE     = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_LIST_FULL = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FIFO_FULL = 2'd3;

	localparam int MaxResults = 16;

	typedef struct packed {
		logic [7:0]  thread;
		logic [7:0]  sem;
		logic [31:0] delta;
	} sleeper_t;

	// Push request from the sleep list engine to the ready FIFO.
	typedef struct packed {
		logic       push;
		logic [7:0] thread;
	} push_req_t;

endpackage

// ----- src/delta_timer_queue_with_ready_fifo.sv -----
// ----------------------------------------------------------------------------
// delta_timer_queue_with_ready_fifo: thread scheduler offload.
// Ready FIFO of thread ids plus a delta-sorted sleep list with timed wakeup.
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  command   start, busy, cmd, thread_id, sleep_ticks,
//            semaphore_id                                   in (busy out)
//  result    result_valid, event_res, out_thread,
//            out_semaphore, status, was_idle, last          out
//  config    cfg_we, cfg_wdata                              in
//
// Enqueue and unknown commands answer in the cycle after acceptance and never
// raise busy; dispatch raises busy in a pop state and answers from there.
// Sleep probes the list entry by entry up to the insertion point and shifts the
// tail up entry by entry; cancel walks the same way and shifts the tail down.
// A tick checks the head and, for each wakeup, shifts the rest of the list
// down. Each shifted entry needs one read and one write of the sleep memory.
// A wakeup result is held until the next entry is checked so it can carry last.
// Reset empties both structures and sets the running thread to the reset idle
// id. The receiver cannot stall: every result is shown for exactly one cycle,
// and the final result of an item carries last.
// ----------------------------------------------------------------------------
module delta_timer_queue_with_ready_fifo #(
	parameter int SLEEP_DEPTH = 16,
	parameter int READY_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [7:0]  thread_id,
	input  logic [31:0] sleep_ticks,
	input  logic [7:0]  semaphore_id,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        result_valid,
	output logic [1:0]  event_res,
	output logic [7:0]  out_thread,
	output logic [7:0]  out_semaphore,
	output logic [1:0]  status,
	output logic        was_idle,
	output logic        last
);
	typedef enum logic [1:0] {T_IDLE, T_POP, T_LIST} top_state_t;

	top_state_t         state_q;
	logic [7:0]         idle_id_q;
	logic [7:0]         running_q;
	logic               accept;
	logic               pop_empty_q;

	logic               f_push;
	logic [7:0]         f_push_data;
	logic               f_pop;
	logic [7:0]         f_pop_data;
	logic               f_full;
	logic               f_empty;

	logic               sl_go;
	dtq_pkg::push_req_t sl_push;
	logic               sl_valid;
	logic [1:0]         sl_event;
	logic [7:0]         sl_thread;
	logic [7:0]         sl_sem;
	logic [1:0]         sl_status;
	logic               sl_last;
	logic               sl_done;

	assign accept = start && !busy;
	assign busy   = (state_q != T_IDLE);
	assign sl_go  = accept && (cmd == dtq_pkg::CMD_SLEEP || cmd == dtq_pkg::CMD_CANCEL ||
		cmd == dtq_pkg::CMD_TICK);

	// The FIFO push comes either straight from an enqueue or from a wakeup.
	assign f_push      = (accept && cmd == dtq_pkg::CMD_ENQUEUE) || sl_push.push;
	assign f_push_data = sl_push.push ? sl_push.thread : thread_id;
	assign f_pop       = accept && cmd == dtq_pkg::CMD_DISPATCH;

	dtq_ready_fifo #(.READY_DEPTH(READY_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(f_push), .push_data(f_push_data),
		.pop(f_pop), .pop_data(f_pop_data),
		.full(f_full), .empty(f_empty)
	);

	dtq_sleep_list #(.SLEEP_DEPTH(SLEEP_DEPTH)) u_sleep (
		.clk(clk), .arst_n(arst_n), .go(sl_go), .cmd(cmd),
		.thread_id(thread_id), .sleep_ticks(sleep_ticks), .semaphore_id(semaphore_id),
		.fifo_full(f_full), .push_req(sl_push),
		.res_valid(sl_valid), .res_event(sl_event), .res_thread(sl_thread),
		.res_sem(sl_sem), .res_status(sl_status), .res_last(sl_last), .done(sl_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_IDLE;
			idle_id_q    <= '0;
			running_q    <= '0;
			pop_empty_q  <= 1'b0;
			result_valid <= 1'b0;
			last         <= 1'b0;
			event_res    <= dtq_pkg::EV_ACK;
			out_thread   <= '0;
			out_semaphore <= '0;
			status       <= dtq_pkg::ST_OK;
			was_idle     <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			last         <= 1'b0;
			if (cfg_we) begin
				idle_id_q <= cfg_wdata;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						if (cmd == dtq_pkg::CMD_ENQUEUE) begin
							// The push lands at this edge, so no busy cycle is needed.
							result_valid  <= 1'b1;
							last          <= 1'b1;
							event_res     <= dtq_pkg::EV_ACK;
							out_thread    <= '0;
							out_semaphore <= '0;
							status        <= f_full ? dtq_pkg::ST_FIFO_FULL : dtq_pkg::ST_OK;
							was_idle      <= 1'b0;
						end else if (cmd == dtq_pkg::CMD_DISPATCH) begin
							pop_empty_q <= f_empty;
							state_q     <= T_POP;
						end else if (sl_go) begin
							state_q <= T_LIST;
						end else begin
							result_valid  <= 1'b1;
							last          <= 1'b1;
							event_res     <= dtq_pkg::EV_ACK;
							out_thread    <= '0;
							out_semaphore <= '0;
							status        <= dtq_pkg::ST_OK;
							was_idle      <= 1'b0;
						end
					end
				end
				T_POP: begin
					running_q     <= pop_empty_q ? idle_id_q : f_pop_data;
					result_valid  <= 1'b1;
					last          <= 1'b1;
					event_res     <= dtq_pkg::EV_DISPATCH;
					out_thread    <= pop_empty_q ? idle_id_q : f_pop_data;
					out_semaphore <= '0;
					status        <= dtq_pkg::ST_OK;
					was_idle      <= pop_empty_q;
					state_q       <= T_IDLE;
				end
				T_LIST: begin
					// Results of the sleep list are passed on one for one.
					if (sl_valid) begin
						result_valid  <= 1'b1;
						last          <= sl_last;
						event_res     <= sl_event;
						out_thread    <= sl_thread;
						out_semaphore <= sl_sem;
						status        <= sl_status;
						was_idle      <= 1'b0;
					end
					if (sl_done) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end
endmodule

// ----- src/dtq_ready_fifo.sv -----
// ----------------------------------------------------------------------------
// dtq_ready_fifo: ready queue of thread ids in a synchronous memory.
// Push and pop are registered; pop data is valid the cycle after the pop.
// ----------------------------------------------------------------------------
module dtq_ready_fifo #(
	parameter int READY_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] push_data,
	input  logic       pop,
	output logic [7:0] pop_data,
	output logic       full,
	output logic       empty
);
	localparam int AW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
	localparam int CW = $clog2(READY_DEPTH + 1);

	logic [7:0]    mem [READY_DEPTH];
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] tail;
	logic [AW:0]   tail_sum;

	assign tail_sum = {1'b0, head_q} + (AW+1)'(count_q);
	assign tail = (tail_sum >= (AW+1)'(READY_DEPTH)) ?
		AW'(tail_sum - (AW+1)'(READY_DEPTH)) : AW'(tail_sum);
	assign full  = (count_q == CW'(READY_DEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[tail] <= push_data;
		end
		pop_data <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop && !empty) begin
				head_q <= (head_q == AW'(READY_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (push && !full && !(pop && !empty)) begin
				count_q <= count_q + 1'b1;
			end else if (!(push && !full) && pop && !empty) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ----- src/dtq_sleep_list.sv -----
// ----------------------------------------------------------------------------
// dtq_sleep_list: delta-sorted sleep list in a synchronous memory.
// Sequencer that walks the list entry by entry for sleep, cancel and tick.
// ----------------------------------------------------------------------------
module dtq_sleep_list #(
	parameter int SLEEP_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [2:0]          cmd,
	input  logic [7:0]          thread_id,
	input  logic [31:0]         sleep_ticks,
	input  logic [7:0]          semaphore_id,
	input  logic                fifo_full,
	output dtq_pkg::push_req_t  push_req,
	output logic                res_valid,
	output logic [1:0]          res_event,
	output logic [7:0]          res_thread,
	output logic [7:0]          res_sem,
	output logic [1:0]          res_status,
	output logic                res_last,
	output logic                done
);
	localparam int AW = (SLEEP_DEPTH > 1) ? $clog2(SLEEP_DEPTH) : 1;
	localparam int CW = $clog2(SLEEP_DEPTH + 1);
	localparam int RW = $clog2(dtq_pkg::MaxResults + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_INS_RD, S_INS_CMP, S_INS_SH_RD, S_INS_SH_WR, S_INS_WR,
		S_CAN_RD, S_CAN_CMP, S_SHL_RD, S_SHL_WR, S_TICK_RD, S_TICK_CHK
	} state_t;

	dtq_pkg::sleeper_t mem [SLEEP_DEPTH];
	dtq_pkg::sleeper_t rd_data;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	dtq_pkg::sleeper_t wr_data;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     pos_q;
	logic [CW-1:0]     idx_q;
	logic [32:0]       remain_q;
	logic [7:0]        thr_q;
	logic [7:0]        sem_q;
	logic [RW-1:0]     nres_q;
	logic              tick_dec_q;
	dtq_pkg::sleeper_t new_q;
	logic [7:0]        pend_thr_q;
	logic [7:0]        pend_sem_q;
	logic [1:0]        pend_st_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data;
		unique case (state_q)
			S_INS_RD, S_CAN_RD, S_SHL_RD: rd_addr = AW'(pos_q);
			S_INS_SH_RD:                  rd_addr = AW'(idx_q - 1'b1);
			S_TICK_RD:                    rd_addr = '0;
			S_INS_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = AW'(idx_q);
			end
			S_INS_WR: begin
				wr_en   = 1'b1;
				wr_addr = AW'(pos_q);
				wr_data = new_q;
			end
			S_SHL_WR: begin
				wr_en   = 1'b1;
				wr_addr = AW'(pos_q - 1'b1);
				if (tick_dec_q) begin
					wr_data.delta = rd_data.delta + new_q.delta;
				end
			end
			S_INS_CMP: begin
				// Successor of the insertion point loses the new delta.
				if (pos_q != count_q && !(remain_q >= {1'b0, rd_data.delta})) begin
					wr_en   = 1'b1;
					wr_addr = AW'(pos_q);
					wr_data.delta = rd_data.delta - remain_q[31:0];
				end
			end
			S_TICK_CHK: begin
				if (tick_dec_q && rd_data.delta != '0) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data.delta = rd_data.delta - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			pos_q      <= '0;
			idx_q      <= '0;
			nres_q     <= '0;
			tick_dec_q <= 1'b0;
			res_valid  <= 1'b0;
			res_last   <= 1'b0;
			done       <= 1'b0;
			push_req   <= '0;
		end else begin
			res_valid <= 1'b0;
			res_last  <= 1'b0;
			done      <= 1'b0;
			push_req  <= '0;
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						pos_q <= '0;
						thr_q <= thread_id;
						sem_q <= semaphore_id;
						remain_q <= {1'b0, (sleep_ticks == '0) ? 32'd1 : sleep_ticks};
						nres_q <= '0;
						tick_dec_q <= 1'b1;
						if (cmd == dtq_pkg::CMD_SLEEP) begin
							if (count_q == CW'(SLEEP_DEPTH)) begin
								res_valid  <= 1'b1;
								res_event  <= dtq_pkg::EV_ACK;
								res_thread <= '0;
								res_sem    <= '0;
								res_status <= dtq_pkg::ST_LIST_FULL;
								res_last   <= 1'b1;
								done       <= 1'b1;
							end else begin
								state_q <= S_INS_RD;
							end
						end else if (cmd == dtq_pkg::CMD_CANCEL) begin
							state_q <= S_CAN_RD;
						end else begin
							state_q <= S_TICK_RD;
						end
					end
				end
				S_INS_RD: state_q <= S_INS_CMP;
				S_INS_CMP: begin
					if (pos_q != count_q && remain_q >= {1'b0, rd_data.delta}) begin
						remain_q <= remain_q - {1'b0, rd_data.delta};
						pos_q    <= pos_q + 1'b1;
						state_q  <= S_INS_RD;
					end else begin
						new_q.thread <= thr_q;
						new_q.sem    <= sem_q;
						new_q.delta  <= remain_q[31:0];
						idx_q        <= count_q;
						state_q      <= (count_q == pos_q) ? S_INS_WR : S_INS_SH_RD;
					end
				end
				S_INS_SH_RD: state_q <= S_INS_SH_WR;
				S_INS_SH_WR: begin
					idx_q   <= idx_q - 1'b1;
					state_q <= (idx_q - 1'b1 == pos_q) ? S_INS_WR : S_INS_SH_RD;
				end
				S_INS_WR: begin
					count_q    <= count_q + 1'b1;
					res_valid  <= 1'b1;
					res_event  <= dtq_pkg::EV_ACK;
					res_thread <= '0;
					res_sem    <= '0;
					res_status <= dtq_pkg::ST_OK;
					res_last   <= 1'b1;
					done       <= 1'b1;
					state_q    <= S_IDLE;
				end
				S_CAN_RD: begin
					if (pos_q == count_q) begin
						res_valid  <= 1'b1;
						res_event  <= dtq_pkg::EV_ACK;
						res_thread <= '0;
						res_sem    <= '0;
						res_status <= dtq_pkg::ST_NOT_FOUND;
						res_last   <= 1'b1;
						done       <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_CAN_CMP;
					end
				end
				S_CAN_CMP: begin
					if (rd_data.thread == thr_q) begin
						// Carry the removed delta into the successor.
						new_q      <= rd_data;
						tick_dec_q <= 1'b1;
						pos_q      <= pos_q + 1'b1;
						state_q    <= S_SHL_RD;
					end else begin
						pos_q   <= pos_q + 1'b1;
						state_q <= S_CAN_RD;
					end
				end
				S_SHL_RD: begin
					if (pos_q == count_q) begin
						count_q <= count_q - 1'b1;
						if (nres_q == '0) begin
							res_valid  <= 1'b1;
							res_event  <= dtq_pkg::EV_ACK;
							res_thread <= '0;
							res_sem    <= '0;
							res_status <= dtq_pkg::ST_OK;
							res_last   <= 1'b1;
							done       <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							pos_q   <= '0;
							state_q <= S_TICK_RD;
						end
					end else begin
						state_q <= S_SHL_WR;
					end
				end
				S_SHL_WR: begin
					tick_dec_q <= 1'b0;
					pos_q      <= pos_q + 1'b1;
					state_q    <= S_SHL_RD;
				end
				S_TICK_RD: begin
					if (count_q == '0 || nres_q == RW'(dtq_pkg::MaxResults)) begin
						// The held wakeup, if any, is the final result.
						res_valid <= 1'b1;
						if (nres_q == '0) begin
							res_event  <= dtq_pkg::EV_NONE;
							res_thread <= '0;
							res_sem    <= '0;
							res_status <= dtq_pkg::ST_OK;
						end else begin
							res_event  <= dtq_pkg::EV_WOKEN;
							res_thread <= pend_thr_q;
							res_sem    <= pend_sem_q;
							res_status <= pend_st_q;
						end
						res_last <= 1'b1;
						done     <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_TICK_CHK;
					end
				end
				S_TICK_CHK: begin
					if (rd_data.delta == '0 || (tick_dec_q && rd_data.delta == 32'd1)) begin
						// Another wakeup follows, so the held one is not the last.
						if (nres_q != '0) begin
							res_valid  <= 1'b1;
							res_event  <= dtq_pkg::EV_WOKEN;
							res_thread <= pend_thr_q;
							res_sem    <= pend_sem_q;
							res_status <= pend_st_q;
						end
						pend_thr_q <= rd_data.thread;
						pend_sem_q <= rd_data.sem;
						pend_st_q  <= fifo_full ? dtq_pkg::ST_FIFO_FULL : dtq_pkg::ST_OK;
						push_req.push   <= 1'b1;
						push_req.thread <= rd_data.thread;
						nres_q     <= nres_q + 1'b1;
						// Remove the head: shift the rest down with no delta carry.
						new_q      <= '0;
						tick_dec_q <= 1'b0;
						pos_q      <= CW'(1);
						state_q    <= S_SHL_RD;
					end else begin
						res_valid <= 1'b1;
						if (nres_q == '0) begin
							res_event  <= dtq_pkg::EV_NONE;
							res_thread <= '0;
							res_sem    <= '0;
							res_status <= dtq_pkg::ST_OK;
						end else begin
							res_event  <= dtq_pkg::EV_WOKEN;
							res_thread <= pend_thr_q;
							res_sem    <= pend_sem_q;
							res_status <= pend_st_q;
						end
						res_last <= 1'b1;
						done     <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- verif/tb_delta_timer_queue_with_ready_fifo.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delta_timer_queue_with_ready_fifo: self-checking bench of the scheduler.
// Commands are driven with random bursts and gaps. Every accepted item runs
// through an in-bench scheduler model, and the results it predicts are
// compared field by field with what the block reports.
// ----------------------------------------------------------------------------
module tb_delta_timer_queue_with_ready_fifo;

	localparam int SleepDepth = 16;
	localparam int ReadyDepth = 32;
	// Longest stretch with no item accepted and no result seen. A tick that
	// wakes a full list costs a shift of the list for each of its 16 wakeups.
	localparam int StallLimit = 20000;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  tid;
		logic [31:0] ticks;
		logic [7:0]  sem;
	} command_t;

	typedef struct packed {
		logic [1:0] ev;
		logic [7:0] thr;
		logic [7:0] sem;
		logic [1:0] st;
		logic       idle;
		logic       fin;
	} report_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [7:0]  thread_id;
	logic [31:0] sleep_ticks;
	logic [7:0]  semaphore_id;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        result_valid;
	logic [1:0]  event_res;
	logic [7:0]  out_thread;
	logic [7:0]  out_semaphore;
	logic [1:0]  status;
	logic        was_idle;
	logic        last;

	delta_timer_queue_with_ready_fifo u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.thread_id    (thread_id),
		.sleep_ticks  (sleep_ticks),
		.semaphore_id (semaphore_id),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.event_res    (event_res),
		.out_thread   (out_thread),
		.out_semaphore(out_semaphore),
		.status       (status),
		.was_idle     (was_idle),
		.last         (last)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Commands waiting to be driven, and reports the model expects next.
	command_t pending_cmds[$];
	report_t  expected_reports[$];

	// Scheduler model state.
	logic [7:0]  idle_id;
	logic [7:0]  ready_ids[ReadyDepth];
	int          ready_head;
	int          ready_count;
	logic [7:0]  sleeper_thr[SleepDepth];
	logic [7:0]  sleeper_sem[SleepDepth];
	logic [31:0] sleeper_delta[SleepDepth];
	int          sleeper_count;
	logic [7:0]  running_id;

	int errors;
	int items_taken;
	int reports_seen;
	int wakeups_seen;
	int full_hits;
	int idle_cycles;
	logic took;

	function automatic report_t make_report(logic [1:0] ev, logic [7:0] thr,
			logic [7:0] sem, logic [1:0] st, logic idle);
		report_t r;
		r.ev = ev;
		r.thr = thr;
		r.sem = sem;
		r.st = st;
		r.idle = idle;
		r.fin = 1'b0;
		return r;
	endfunction

	function automatic logic [1:0] ready_append(logic [7:0] t);
		if (ready_count >= ReadyDepth)
			return dtq_pkg::ST_FIFO_FULL;
		ready_ids[(ready_head + ready_count) % ReadyDepth] = t;
		ready_count++;
		return dtq_pkg::ST_OK;
	endfunction

	function automatic void sleeper_drop(int pos);
		for (int i = pos; i < sleeper_count - 1; i++) begin
			sleeper_thr[i] = sleeper_thr[i + 1];
			sleeper_sem[i] = sleeper_sem[i + 1];
			sleeper_delta[i] = sleeper_delta[i + 1];
		end
		sleeper_count--;
	endfunction

	function automatic logic [1:0] sleeper_insert(logic [7:0] t, logic [31:0] ticks,
			logic [7:0] sem);
		logic [63:0] wake;
		logic [63:0] cum;
		int pos;
		if (sleeper_count >= SleepDepth)
			return dtq_pkg::ST_LIST_FULL;
		// A zero sleep time counts as one tick.
		wake = (ticks == 0) ? 64'd1 : {32'd0, ticks};
		cum = 0;
		pos = 0;
		// Equal wake times keep insertion order: walk past them.
		while (pos < sleeper_count && cum + sleeper_delta[pos] <= wake) begin
			cum += sleeper_delta[pos];
			pos++;
		end
		for (int i = sleeper_count; i > pos; i--) begin
			sleeper_thr[i] = sleeper_thr[i - 1];
			sleeper_sem[i] = sleeper_sem[i - 1];
			sleeper_delta[i] = sleeper_delta[i - 1];
		end
		sleeper_thr[pos] = t;
		sleeper_sem[pos] = sem;
		sleeper_delta[pos] = 32'(wake - cum);
		if (pos < sleeper_count)
			sleeper_delta[pos + 1] -= sleeper_delta[pos];
		sleeper_count++;
		return dtq_pkg::ST_OK;
	endfunction

	function automatic logic [1:0] sleeper_cancel(logic [7:0] t);
		for (int pos = 0; pos < sleeper_count; pos++) begin
			if (sleeper_thr[pos] == t) begin
				if (pos + 1 < sleeper_count)
					sleeper_delta[pos + 1] += sleeper_delta[pos];
				sleeper_drop(pos);
				return dtq_pkg::ST_OK;
			end
		end
		return dtq_pkg::ST_NOT_FOUND;
	endfunction

	// Advances the model by one command and queues the reports it causes.
	function automatic void schedule_command(command_t c);
		report_t batch[$];
		report_t r;
		case (c.op)
			dtq_pkg::CMD_ENQUEUE: batch.push_back(make_report(dtq_pkg::EV_ACK, 8'd0, 8'd0,
					ready_append(c.tid), 1'b0));
			dtq_pkg::CMD_DISPATCH: begin
				if (ready_count == 0) begin
					running_id = idle_id;
					batch.push_back(make_report(dtq_pkg::EV_DISPATCH, running_id, 8'd0,
						dtq_pkg::ST_OK, 1'b1));
				end else begin
					running_id = ready_ids[ready_head];
					ready_head = (ready_head + 1) % ReadyDepth;
					ready_count--;
					batch.push_back(make_report(dtq_pkg::EV_DISPATCH, running_id, 8'd0,
						dtq_pkg::ST_OK, 1'b0));
				end
			end
			dtq_pkg::CMD_SLEEP: batch.push_back(make_report(dtq_pkg::EV_ACK, 8'd0, 8'd0,
					sleeper_insert(c.tid, c.ticks, c.sem), 1'b0));
			dtq_pkg::CMD_CANCEL: batch.push_back(make_report(dtq_pkg::EV_ACK, 8'd0, 8'd0,
					sleeper_cancel(c.tid), 1'b0));
			dtq_pkg::CMD_TICK: begin
				// Entries left at zero by an earlier tick wake without a decrement.
				if (sleeper_count > 0 && sleeper_delta[0] != 0)
					sleeper_delta[0]--;
				while (sleeper_count > 0 && sleeper_delta[0] == 0
						&& batch.size() < dtq_pkg::MaxResults) begin
					r = make_report(dtq_pkg::EV_WOKEN, sleeper_thr[0], sleeper_sem[0],
						dtq_pkg::ST_OK, 1'b0);
					sleeper_drop(0);
					r.st = ready_append(r.thr);
					batch.push_back(r);
				end
				if (batch.size() == 0)
					batch.push_back(make_report(dtq_pkg::EV_NONE, 8'd0, 8'd0,
						dtq_pkg::ST_OK, 1'b0));
			end
			default: batch.push_back(make_report(dtq_pkg::EV_ACK, 8'd0, 8'd0,
					dtq_pkg::ST_OK, 1'b0));
		endcase
		batch[batch.size() - 1].fin = 1'b1;
		foreach (batch[i])
			expected_reports.push_back(batch[i]);
	endfunction

	// Driver: bursts of back-to-back commands separated by random gaps.
	int burst_left;
	int gap_left;
	command_t next_cmd;

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			burst_left <= $urandom_range(1, 12);
			gap_left <= 0;
		end else if (start && !took) begin
			// The block has not taken the current command yet: hold it.
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_cmds.size() > 0) begin
			next_cmd = pending_cmds.pop_front();
			cmd <= next_cmd.op;
			thread_id <= next_cmd.tid;
			sleep_ticks <= next_cmd.ticks;
			semaphore_id <= next_cmd.sem;
			start <= 1'b1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 12);
				// Some bursts run straight into the next one.
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: takes accepted commands into the model and checks each report.
	report_t want;

	always @(posedge clk) begin
		took = 1'b0;
		if (arst_n) begin
			idle_cycles++;
			if (start && !busy) begin
				took = 1'b1;
				items_taken++;
				idle_cycles = 0;
				schedule_command({cmd, thread_id, sleep_ticks, semaphore_id});
			end
			if (result_valid) begin
				reports_seen++;
				idle_cycles = 0;
				if (event_res == dtq_pkg::EV_WOKEN)
					wakeups_seen++;
				if (status == dtq_pkg::ST_FIFO_FULL || status == dtq_pkg::ST_LIST_FULL)
					full_hits++;
				if (expected_reports.size() == 0) begin
					errors++;
					$display("%0t: report with none expected: ev=%0d thr=%0d sem=%0d st=%0d",
						$time, event_res, out_thread, out_semaphore, status);
				end else begin
					want = expected_reports.pop_front();
					if (event_res !== want.ev) begin
						errors++;
						$display("%0t: event_res expected %0d actual %0d", $time, want.ev, event_res);
					end
					if (out_thread !== want.thr) begin
						errors++;
						$display("%0t: out_thread expected %0d actual %0d",
							$time, want.thr, out_thread);
					end
					if (out_semaphore !== want.sem) begin
						errors++;
						$display("%0t: out_semaphore expected %0d actual %0d",
							$time, want.sem, out_semaphore);
					end
					if (status !== want.st) begin
						errors++;
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					end
					if (was_idle !== want.idle) begin
						errors++;
						$display("%0t: was_idle expected %0d actual %0d",
							$time, want.idle, was_idle);
					end
					if (last !== want.fin) begin
						errors++;
						$display("%0t: last expected %0d actual %0d", $time, want.fin, last);
					end
				end
			end
			if (idle_cycles >= StallLimit) begin
				$display("%0t: no progress for %0d cycles", $time, StallLimit);
				$display("tb_delta_timer_queue_with_ready_fifo: errors");
				$finish;
			end
		end
	end

	function automatic command_t make_cmd(logic [2:0] op, logic [7:0] tid,
			logic [31:0] ticks, logic [7:0] sem);
		command_t c;
		c.op = op;
		c.tid = tid;
		c.ticks = ticks;
		c.sem = sem;
		return c;
	endfunction

	// Random traffic. Thread ids mostly come from a small pool so that cancels
	// hit sleepers, and sleep times are mostly short so that ticks wake them.
	task automatic queue_random(int count);
		command_t c;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			c.tid = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
			c.sem = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
			c.ticks = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 6));
			if (pick < 15)
				c.op = dtq_pkg::CMD_ENQUEUE;
			else if (pick < 30)
				c.op = dtq_pkg::CMD_DISPATCH;
			else if (pick < 55)
				c.op = dtq_pkg::CMD_SLEEP;
			else if (pick < 65)
				c.op = dtq_pkg::CMD_CANCEL;
			else if (pick < 97)
				c.op = dtq_pkg::CMD_TICK;
			else
				c.op = 3'($urandom_range(5, 7));
			pending_cmds.push_back(c);
		end
	endtask

	// Lets all queued commands drain, then a margin for the last shifts.
	task automatic settle();
		do
			@(posedge clk);
		while (!(pending_cmds.size() == 0 && !start && !busy
				&& expected_reports.size() == 0));
		repeat (200) @(posedge clk);
	endtask

	task automatic write_idle_id(logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		idle_id = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		errors = 0;
		items_taken = 0;
		reports_seen = 0;
		wakeups_seen = 0;
		full_hits = 0;
		idle_cycles = 0;
		took = 1'b0;
		idle_id = 8'd0;
		running_id = 8'd0;
		ready_head = 0;
		ready_count = 0;
		sleeper_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = dtq_pkg::CMD_ENQUEUE;
		thread_id = 8'd0;
		sleep_ticks = 32'd0;
		semaphore_id = 8'd0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: dispatch on an empty queue gives the reset idle id, then
		// the basic commands, zero and maximal sleep times, equal wake times,
		// a cancel of a thread that is not asleep and unknown commands.
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_DISPATCH, 8'd0, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_TICK, 8'd0, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_ENQUEUE, 8'hFF, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_DISPATCH, 8'd0, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_SLEEP, 8'd1, 32'hFFFF_FFFF, 8'hFF));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_SLEEP, 8'd2, 32'd0, 8'd7));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_SLEEP, 8'd3, 32'd2, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_SLEEP, 8'd4, 32'd2, 8'hAA));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_SLEEP, 8'd5, 32'd1, 8'h55));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_CANCEL, 8'd9, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_CANCEL, 8'd3, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_TICK, 8'd0, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_TICK, 8'd0, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_CANCEL, 8'd1, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(3'd5, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
		pending_cmds.push_back(make_cmd(3'd6, 8'd0, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(3'd7, 8'd0, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_DISPATCH, 8'd0, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_DISPATCH, 8'd0, 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_DISPATCH, 8'd0, 32'd0, 8'd0));
		settle();

		// Full structures: fill the sleep list past its depth with one wake
		// time, fill the ready queue past its depth, then wake the whole list
		// into a full queue in a single tick.
		write_idle_id(8'hFF);
		for (int i = 0; i <= SleepDepth; i++)
			pending_cmds.push_back(make_cmd(dtq_pkg::CMD_SLEEP, 8'(i + 32), 32'd1, 8'(i)));
		for (int i = 0; i <= ReadyDepth; i++)
			pending_cmds.push_back(make_cmd(dtq_pkg::CMD_ENQUEUE, 8'(i), 32'd0, 8'd0));
		pending_cmds.push_back(make_cmd(dtq_pkg::CMD_TICK, 8'd0, 32'd0, 8'd0));
		for (int i = 0; i <= ReadyDepth; i++)
			pending_cmds.push_back(make_cmd(dtq_pkg::CMD_DISPATCH, 8'd0, 32'd0, 8'd0));
		settle();

		// Random phases, each under another idle id.
		queue_random(115);
		settle();
		write_idle_id(8'd0);
		queue_random(115);
		settle();
		write_idle_id(8'($urandom));
		queue_random(115);
		settle();

		$display("Took %0d commands and checked %0d reports, %0d of them wakeups,",
			items_taken, reports_seen, wakeups_seen);
		$display("%0d reports of a full sleep list or ready queue, idle ids 0, 255, random.",
			full_hits);
		if (errors == 0)
			$display("tb_delta_timer_queue_with_ready_fifo: clean");
		else
			$display("tb_delta_timer_queue_with_ready_fifo: errors");
		$finish;
	end

endmodule

// ----- files.f -----
src/dtq_pkg.sv
src/dtq_ready_fifo.sv
src/dtq_sleep_list.sv
src/delta_timer_queue_with_ready_fifo.sv
verif/tb_delta_timer_queue_with_ready_fifo.sv
